### design/prefix_code_bit_decoder_macros.svh
// ----------------------------------------------------------------------------
// Prefix code bit decoder assertion macros
// Shared concurrent assertion forms for the decoder checker.
// ----------------------------------------------------------------------------
`ifndef PREFIX_CODE_BIT_DECODER_MACROS_SVH
`define PREFIX_CODE_BIT_DECODER_MACROS_SVH

// Checked on every clock edge outside reset.
`define PCBD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PCBD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/pcbd_pkg.sv
// ----------------------------------------------------------------------------
// Prefix code bit decoder package
// Request codes, controller states, result type and table helpers.
// ----------------------------------------------------------------------------
package pcbd_pkg;

  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int NUM_SYMBOLS_DEF  = 256;

  localparam int SYM_W   = 8;
  localparam int LEN_W   = 6;
  localparam int CODE_W  = 32;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 4;

  // table is split into lanes, one row of lanes compared per cycle
  localparam int LANES   = 8;
  localparam int LANE_W  = $clog2(LANES);

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_FINAL = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIT,
    S_SCAN,
    S_PUSH,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             err;
  } res_t;

  // keep only the low len bits of a codeword
  function automatic logic [CODE_W-1:0] code_mask(input logic [CODE_W-1:0] code,
                                                 input logic [LEN_W-1:0]  len);
    logic [CODE_W:0] mask;
    if (len >= LEN_W'(CODE_W)) begin
      mask = '1;
    end else begin
      mask = ((CODE_W+1)'(1) << len) - (CODE_W+1)'(1);
    end
    return code & mask[CODE_W-1:0];
  endfunction

endpackage

### design/prefix_code_bit_decoder.sv
// ----------------------------------------------------------------------------
// Prefix code bit decoder
// Table-matching decoder for a prefix code of up to NUM_SYMBOLS byte symbols.
// ----------------------------------------------------------------------------
// A load request writes one codeword and its length into the table. A data
// request is shifted in one bit at a time; after each bit the table is scanned
// row by row, LANES entries per row, from a banked table memory with a
// registered read. Each bit is shifted in, then scanned over up to ROWS rows
// (ROWS = NUM_SYMBOLS / LANES rounded up, the scan stops at the first matching
// row), then any result is pushed once the output slot is free. Each result is
// held back until the next one or the end of its request, so the final result
// of a request carries last. A new request is taken only once the previous
// one has left all its results in the output register.
module prefix_code_bit_decoder #(
  parameter int MAX_CODE_LEN = pcbd_pkg::MAX_CODE_LEN_DEF,
  parameter int NUM_SYMBOLS  = pcbd_pkg::NUM_SYMBOLS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   op,
  input  logic [pcbd_pkg::SYM_W-1:0]   entry_symbol,
  input  logic [pcbd_pkg::LEN_W-1:0]   entry_length,
  input  logic [pcbd_pkg::CODE_W-1:0]  entry_code,
  input  logic [pcbd_pkg::BYTE_W-1:0]  data_byte,
  input  logic [pcbd_pkg::CNT_W-1:0]   bit_count,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pcbd_pkg::SYM_W-1:0]   symbol,
  output logic                         error,
  output logic                         last
);

  localparam int LANES  = pcbd_pkg::LANES;
  localparam int LANE_W = pcbd_pkg::LANE_W;
  localparam int ROWS   = (NUM_SYMBOLS + LANES - 1) / LANES;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PLW    = $clog2(MAX_CODE_LEN + 1);
  localparam int CMPW   = (PLW > pcbd_pkg::LEN_W) ? PLW : pcbd_pkg::LEN_W;
  localparam int PW     = (MAX_CODE_LEN > pcbd_pkg::CODE_W) ? MAX_CODE_LEN
                                                             : pcbd_pkg::CODE_W;

  pcbd_pkg::state_t state, state_next;

  logic [pcbd_pkg::BYTE_W-1:0] dbits, dbits_next;
  logic [pcbd_pkg::CNT_W-1:0]  bits_left, bits_left_next;
  logic                        is_final, is_final_next;
  logic [MAX_CODE_LEN-1:0]     prefix, prefix_next;
  logic [PLW-1:0]              plen, plen_next;
  logic [ROW_W-1:0]            rd_row, rd_row_next;
  logic [ROW_W-1:0]            raddr;
  pcbd_pkg::res_t              new_res, new_res_next;
  pcbd_pkg::res_t              pend, pend_next;
  logic                        pend_valid, pend_valid_next;
  pcbd_pkg::res_t              out_res, out_res_next;
  logic                        out_last, out_last_next;
  logic                        out_valid_next;

  logic                        load_we;
  logic [LANE_W-1:0]           load_lane;
  logic [ROW_W-1:0]            load_row;
  logic [pcbd_pkg::CODE_W-1:0] load_code;

  logic [pcbd_pkg::CODE_W-1:0] rcode [LANES];
  logic [pcbd_pkg::LEN_W-1:0]  rlen  [LANES];
  logic                        rvld  [LANES];
  logic                        vld   [LANES][ROWS];
  logic [LANES-1:0]            hit;
  logic                        hit_any;
  logic [LANE_W-1:0]           hit_lane;
  logic                        slot_free;
  logic [pcbd_pkg::CNT_W-1:0]  tail_bits;

  assign in_ready  = (state == pcbd_pkg::S_IDLE);
  assign symbol    = out_res.sym;
  assign error     = out_res.err;
  assign last      = out_last;
  assign slot_free = !out_valid || out_ready;

  assign load_we   = in_valid && in_ready && (op == pcbd_pkg::OP_LOAD) &&
                     ((pcbd_pkg::SYM_W + 1)'(entry_symbol) <
                      (pcbd_pkg::SYM_W + 1)'(NUM_SYMBOLS));
  assign load_lane = entry_symbol[LANE_W-1:0];
  assign load_row  = ROW_W'(entry_symbol >> LANE_W);
  assign load_code = pcbd_pkg::code_mask(entry_code, entry_length);
  assign tail_bits = (bit_count > pcbd_pkg::CNT_W'(pcbd_pkg::BYTE_W)) ?
                     pcbd_pkg::CNT_W'(pcbd_pkg::BYTE_W) : bit_count;

  // table lanes
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [pcbd_pkg::CODE_W-1:0] code_mem [ROWS];
    logic [pcbd_pkg::LEN_W-1:0]  len_mem  [ROWS];

    always_ff @(posedge clk) begin
      if (load_we && (load_lane == LANE_W'(l))) begin
        code_mem[load_row] <= load_code;
        len_mem[load_row]  <= entry_length;
      end
      rcode[l] <= code_mem[raddr];
      rlen[l]  <= len_mem[raddr];
      rvld[l]  <= vld[l][raddr];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        for (int r = 0; r < ROWS; r++) begin
          vld[l][r] <= 1'b0;
        end
      end else if (load_we && (load_lane == LANE_W'(l))) begin
        vld[l][load_row] <= (entry_length != '0);
      end
    end

    assign hit[l] = rvld[l] &&
                    (CMPW'(rlen[l]) == CMPW'(plen)) &&
                    (PW'(rcode[l]) == PW'(prefix));
  end

  always_comb begin
    hit_lane = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (hit[l]) begin
        hit_lane = LANE_W'(l);
      end
    end
  end

  assign hit_any = |hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pcbd_pkg::S_IDLE;
      prefix     <= '0;
      plen       <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      prefix     <= prefix_next;
      plen       <= plen_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    dbits     <= dbits_next;
    bits_left <= bits_left_next;
    is_final  <= is_final_next;
    rd_row    <= rd_row_next;
    new_res   <= new_res_next;
    pend      <= pend_next;
    out_res   <= out_res_next;
    out_last  <= out_last_next;
  end

  always_comb begin
    state_next      = state;
    dbits_next      = dbits;
    bits_left_next  = bits_left;
    is_final_next   = is_final;
    prefix_next     = prefix;
    plen_next       = plen;
    rd_row_next     = rd_row;
    raddr           = '0;
    new_res_next    = new_res;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    out_res_next    = out_res;
    out_last_next   = out_last;
    out_valid_next  = out_valid && !out_ready;

    unique case (state)
      pcbd_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (op)
            pcbd_pkg::OP_BYTE: begin
              dbits_next     = data_byte;
              bits_left_next = pcbd_pkg::CNT_W'(pcbd_pkg::BYTE_W);
              is_final_next  = 1'b0;
              state_next     = pcbd_pkg::S_BIT;
            end
            pcbd_pkg::OP_FINAL: begin
              if (tail_bits == '0) begin
                prefix_next = '0;
                plen_next   = '0;
              end else begin
                dbits_next     = data_byte;
                bits_left_next = tail_bits;
                is_final_next  = 1'b1;
                state_next     = pcbd_pkg::S_BIT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      pcbd_pkg::S_BIT: begin
        prefix_next    = MAX_CODE_LEN'({prefix, dbits[pcbd_pkg::BYTE_W-1]});
        plen_next      = plen + PLW'(1);
        dbits_next     = dbits << 1;
        bits_left_next = bits_left - pcbd_pkg::CNT_W'(1);
        raddr          = '0;
        rd_row_next    = '0;
        state_next     = pcbd_pkg::S_SCAN;
      end

      pcbd_pkg::S_SCAN: begin
        raddr       = rd_row + ROW_W'(1);
        rd_row_next = rd_row + ROW_W'(1);
        if (hit_any) begin
          new_res_next.sym = pcbd_pkg::SYM_W'({rd_row, hit_lane});
          new_res_next.err = 1'b0;
          prefix_next      = '0;
          plen_next        = '0;
          state_next       = pcbd_pkg::S_PUSH;
        end else if (rd_row == ROW_W'(ROWS - 1)) begin
          if (plen == PLW'(MAX_CODE_LEN)) begin
            new_res_next.sym = '0;
            new_res_next.err = 1'b1;
            prefix_next      = '0;
            plen_next        = '0;
            state_next       = pcbd_pkg::S_PUSH;
          end else if (bits_left != '0) begin
            state_next = pcbd_pkg::S_BIT;
          end else begin
            state_next = pcbd_pkg::S_FLUSH;
          end
        end
      end

      pcbd_pkg::S_PUSH: begin
        if (slot_free) begin
          if (pend_valid) begin
            out_res_next   = pend;
            out_last_next  = 1'b0;
            out_valid_next = 1'b1;
          end
          pend_next       = new_res;
          pend_valid_next = 1'b1;
          state_next      = (bits_left != '0) ? pcbd_pkg::S_BIT : pcbd_pkg::S_FLUSH;
        end
      end

      pcbd_pkg::S_FLUSH: begin
        if (!pend_valid || slot_free) begin
          if (pend_valid) begin
            out_res_next    = pend;
            out_last_next   = 1'b1;
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
          end
          if (is_final) begin
            prefix_next = '0;
            plen_next   = '0;
          end
          state_next = pcbd_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = pcbd_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### design/pcbd_checker.sv
// ----------------------------------------------------------------------------
// Prefix code bit decoder checker
// Port-level assertions, bound to the decoder top level.
// ----------------------------------------------------------------------------
`include "prefix_code_bit_decoder_macros.svh"

module pcbd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [1:0]                  op,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [pcbd_pkg::SYM_W-1:0]  symbol,
  input logic                        error,
  input logic                        last
);

  `PCBD_ASSERT_ALWAYS(a_rst_idle, clk, rst |=> !out_valid, "result valid after reset")

  `PCBD_ASSERT(a_out_hold, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(symbol) && $stable(error) && $stable(last)), "stalled result changed")

  `PCBD_ASSERT(a_err_sym, clk, rst, (out_valid && error) |-> (symbol == '0), "error result with nonzero symbol")

  `PCBD_ASSERT(a_load_quiet, clk, rst, (in_valid && in_ready && (op == pcbd_pkg::OP_LOAD) && !out_valid) |=> !out_valid, "load request produced a result")

endmodule

bind prefix_code_bit_decoder pcbd_checker u_pcbd_checker (.*);

### tb/tb_prefix_code_bit_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prefix code bit decoder testbench
// Loads codeword tables and streams coded bytes into the decoder. A scripted
// opening covers empty tables, full-length codes, shared codewords, unused and
// overlong entries and end-of-stream handling. Random phases follow, each with
// a fresh prefix-free table, mostly well-formed coded streams with some noise,
// and different idle and stall mixes on the two handshakes. Every returned
// symbol is checked in order against its scripted value or a bit-serial decode
// kept in the bench.
module tb_prefix_code_bit_decoder;

  localparam int CLK_PERIOD     = 20;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 300;
  localparam int STREAM_ITEMS   = 45;
  localparam int CODE_LIMIT     = pcbd_pkg::MAX_CODE_LEN_DEF;
  localparam int TABLE_SIZE     = pcbd_pkg::NUM_SYMBOLS_DEF;
  localparam int MAX_TREE_DEPTH = 20;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]                  op;
    logic [pcbd_pkg::SYM_W-1:0]  sym;
    logic [pcbd_pkg::LEN_W-1:0]  len;
    logic [pcbd_pkg::CODE_W-1:0] code;
    logic [pcbd_pkg::BYTE_W-1:0] data;
    logic [pcbd_pkg::CNT_W-1:0]  cnt;
  } request_t;

  typedef struct packed {
    logic [pcbd_pkg::SYM_W-1:0] sym;
    logic                       err;
    logic                       last;
  } decoded_t;

  typedef struct packed {
    request_t                   req;
    logic                       typed;
    logic                       hit;
    logic [pcbd_pkg::SYM_W-1:0] sym;
    logic                       err;
  } script_row_t;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  logic [1:0]                   op;
  logic [pcbd_pkg::SYM_W-1:0]   entry_symbol;
  logic [pcbd_pkg::LEN_W-1:0]   entry_length;
  logic [pcbd_pkg::CODE_W-1:0]  entry_code;
  logic [pcbd_pkg::BYTE_W-1:0]  data_byte;
  logic [pcbd_pkg::CNT_W-1:0]   bit_count;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [pcbd_pkg::SYM_W-1:0]   symbol;
  logic                         error;
  logic                         last;

  prefix_code_bit_decoder uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .entry_symbol (entry_symbol),
    .entry_length (entry_length),
    .entry_code   (entry_code),
    .data_byte    (data_byte),
    .bit_count    (bit_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .symbol       (symbol),
    .error        (error),
    .last         (last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // decoder state as seen by the bench
  logic [pcbd_pkg::CODE_W-1:0] cw_bits [TABLE_SIZE];
  logic [pcbd_pkg::LEN_W-1:0]  cw_len  [TABLE_SIZE];
  bit                          cw_live [TABLE_SIZE];
  logic [pcbd_pkg::CODE_W-1:0] acc_bits;
  int                          acc_len;

  decoded_t fresh [8];
  int       fresh_n;
  decoded_t symbols_due [$];

  // current well-formed code, used to build coded streams
  logic [pcbd_pkg::CODE_W-1:0] word_code [$];
  int                          word_len  [$];
  bit                          coded_bits [$];

  script_row_t script [$];

  int send_gap_pct;
  int recv_stall_pct;
  int mismatches = 0;
  int idle_cycles = 0;

  int gap_mix   [4] = '{0, 46, 0, 18};
  int stall_mix [4] = '{0, 0, 46, 18};

  function automatic void decode_request(input request_t r);
    int       nbits;
    bit       found;
    logic [pcbd_pkg::CODE_W:0] mask;
    decoded_t d;
    fresh_n = 0;
    if (r.op == pcbd_pkg::OP_LOAD) begin
      cw_bits[r.sym] = r.code;
      cw_len[r.sym]  = r.len;
      cw_live[r.sym] = (r.len != '0);
      return;
    end
    if (r.op == OP_NONE) return;
    nbits = (r.op == pcbd_pkg::OP_BYTE) ? 8 : ((r.cnt > 8) ? 8 : int'(r.cnt));
    for (int b = 0; b < nbits; b++) begin
      acc_bits = {acc_bits[CODE_LIMIT-2:0], r.data[7-b]};
      acc_len++;
      found = 1'b0;
      d = '0;
      for (int s = 0; s < TABLE_SIZE && !found; s++) begin
        mask = (33'd1 << cw_len[s]) - 33'd1;
        if (cw_live[s] && int'(cw_len[s]) == acc_len &&
            (cw_bits[s] & mask[pcbd_pkg::CODE_W-1:0]) == acc_bits) begin
          d.sym = 8'(s);
          found = 1'b1;
        end
      end
      if (!found && acc_len >= CODE_LIMIT) begin
        d.err = 1'b1;
        found = 1'b1;
      end
      if (found) begin
        fresh[fresh_n] = d;
        fresh_n++;
        acc_bits = '0;
        acc_len  = 0;
      end
    end
    if (fresh_n > 0) fresh[fresh_n-1].last = 1'b1;
    if (r.op == pcbd_pkg::OP_FINAL) begin
      acc_bits = '0;
      acc_len  = 0;
    end
  endfunction

  function automatic request_t scrambled_request();
    request_t r;
    r.op   = 2'($urandom_range(3));
    r.sym  = 8'($urandom);
    r.len  = 6'($urandom);
    r.code = $urandom;
    r.data = 8'($urandom);
    r.cnt  = 4'($urandom);
    return r;
  endfunction

  function automatic void add_row(input logic [1:0] o, input logic [7:0] s,
                                  input logic [5:0] l, input logic [31:0] c,
                                  input logic [7:0] d, input logic [3:0] n,
                                  input bit typed, input bit hit,
                                  input logic [7:0] esym, input logic eerr);
    script_row_t row;
    row.req   = '{op: o, sym: s, len: l, code: c, data: d, cnt: n};
    row.typed = typed;
    row.hit   = hit;
    row.sym   = esym;
    row.err   = eerr;
    script.push_back(row);
  endfunction

  function automatic void spell_symbol();
    int k;
    k = $urandom_range(word_code.size() - 1);
    for (int i = word_len[k] - 1; i >= 0; i--) coded_bits.push_back(word_code[k][i]);
  endfunction

  task automatic push_request(input request_t r, input bit typed, input bit hit,
                              input logic [7:0] esym, input logic eerr);
    decoded_t d;
    @(negedge clk);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    op           <= r.op;
    entry_symbol <= r.sym;
    entry_length <= r.len;
    entry_code   <= r.code;
    data_byte    <= r.data;
    bit_count    <= r.cnt;
    do @(posedge clk); while (!in_ready);
    decode_request(r);
    if (typed) begin
      if (hit) begin
        d.sym  = esym;
        d.err  = eerr;
        d.last = 1'b1;
        symbols_due.push_back(d);
      end
    end else begin
      for (int i = 0; i < fresh_n; i++) symbols_due.push_back(fresh[i]);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (symbols_due.size() != 0) @(posedge clk);
  endtask

  // retire the live entries, then load a random prefix-free code
  task automatic build_code_table();
    bit       taken [TABLE_SIZE];
    request_t r;
    int       k;
    int       target;
    int       s;
    logic [pcbd_pkg::CODE_W-1:0] c;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      taken[i] = 1'b0;
      if (cw_live[i]) begin
        r = scrambled_request();
        r.op  = pcbd_pkg::OP_LOAD;
        r.sym = 8'(i);
        r.len = '0;
        push_request(r, 1'b0, 1'b0, '0, 1'b0);
      end
    end
    word_code = {32'd0, 32'd1};
    word_len  = {1, 1};
    target = $urandom_range(2, 40);
    while (word_code.size() < target) begin
      k = $urandom_range(word_code.size() - 1);
      if (word_len[k] < MAX_TREE_DEPTH) begin
        c = word_code[k];
        word_code[k] = c << 1;
        word_len[k]  = word_len[k] + 1;
        word_code.push_back((c << 1) | 32'd1);
        word_len.push_back(word_len[k]);
      end
    end
    // an incomplete code lets stray prefixes run into the length limit
    if ($urandom_range(1) == 1) begin
      k = $urandom_range(word_code.size() - 1);
      word_code.delete(k);
      word_len.delete(k);
    end
    for (int i = 0; i < word_code.size(); i++) begin
      do s = $urandom_range(TABLE_SIZE - 1); while (taken[s]);
      taken[s] = 1'b1;
      r = scrambled_request();
      r.op   = pcbd_pkg::OP_LOAD;
      r.sym  = 8'(s);
      r.len  = 6'(word_len[i]);
      r.code = word_code[i] | ($urandom << word_len[i]);
      push_request(r, 1'b0, 1'b0, '0, 1'b0);
    end
    coded_bits.delete();
  endtask

  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin : check_results
    decoded_t want;
    if (!rst && out_valid && out_ready) begin
      if (symbols_due.size() == 0) begin
        $error("unexpected result: symbol %0d error %0d last %0d", symbol, error, last);
        mismatches++;
      end else begin
        want = symbols_due.pop_front();
        if (symbol !== want.sym) begin
          $error("symbol mismatch: expected %0d, got %0d", want.sym, symbol);
          mismatches++;
        end
        if (error !== want.err) begin
          $error("error mismatch: expected %0d, got %0d", want.err, error);
          mismatches++;
        end
        if (last !== want.last) begin
          $error("last mismatch: expected %0d, got %0d", want.last, last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_prefix_code_bit_decoder NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    request_t r;
    int       n;
    int       pick;
    int       nb;
    bit       skip;

    rst          = 1'b1;
    in_valid     = 1'b0;
    op           = pcbd_pkg::OP_LOAD;
    entry_symbol = '0;
    entry_length = '0;
    entry_code   = '0;
    data_byte    = '0;
    bit_count    = '0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    acc_bits = '0;
    acc_len  = 0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      cw_bits[i] = '0;
      cw_len[i]  = '0;
      cw_live[i] = 1'b0;
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    //      op                  sym     len    code           data   cnt  typ hit esym  err
    add_row(OP_NONE,            8'hFF,  6'd63, 32'hFFFFFFFF,  8'hFF, 4'd15, 1, 0, 8'd0,   0);
    add_row(pcbd_pkg::OP_BYTE,  8'h00,  6'd0,  32'h0,         8'h00, 4'd0,  1, 0, 8'd0,   0);
    add_row(pcbd_pkg::OP_BYTE,  8'h00,  6'd0,  32'h0,         8'hFF, 4'd0,  1, 0, 8'd0,   0);
    add_row(pcbd_pkg::OP_BYTE,  8'h00,  6'd0,  32'h0,         8'hA5, 4'd0,  1, 0, 8'd0,   0);
    // empty table: 32nd bit ends the prefix in an error
    add_row(pcbd_pkg::OP_BYTE,  8'h00,  6'd0,  32'h0,         8'h00, 4'd0,  1, 1, 8'd0,   1);
    add_row(pcbd_pkg::OP_LOAD,  8'd255, 6'd32, 32'hDEADBEEF,  8'h00, 4'd0,  1, 0, 8'd0,   0);
    add_row(pcbd_pkg::OP_BYTE,  8'h00,  6'd0,  32'h0,         8'hDE, 4'd0,  1, 0, 8'd0,   0);
    add_row(pcbd_pkg::OP_BYTE,  8'h00,  6'd0,  32'h0,         8'hAD, 4'd0,  1, 0, 8'd0,   0);
    add_row(pcbd_pkg::OP_BYTE,  8'h00,  6'd0,  32'h0,         8'hBE, 4'd0,  1, 0, 8'd0,   0);
    // full-length codeword wins over the length-limit error
    add_row(pcbd_pkg::OP_BYTE,  8'h00,  6'd0,  32'h0,         8'hEF, 4'd0,  1, 1, 8'd255, 0);
    // junk above the codeword length, and two symbols sharing one codeword
    add_row(pcbd_pkg::OP_LOAD,  8'd9,   6'd1,  32'hFFFFFFFE,  8'h00, 4'd0,  1, 0, 8'd0,   0);
    add_row(pcbd_pkg::OP_LOAD,  8'd200, 6'd1,  32'h0,         8'h00, 4'd0,  1, 0, 8'd0,   0);
    add_row(pcbd_pkg::OP_LOAD,  8'd12,  6'd2,  32'h2,         8'h00, 4'd0,  1, 0, 8'd0,   0);
    add_row(pcbd_pkg::OP_LOAD,  8'd13,  6'd2,  32'h7,         8'h00, 4'd0,  1, 0, 8'd0,   0);
    add_row(pcbd_pkg::OP_BYTE,  8'h00,  6'd0,  32'h0,         8'h00, 4'd0,  0, 0, 8'd0,   0);
    // bit count above eight
    add_row(pcbd_pkg::OP_FINAL, 8'h00,  6'd0,  32'h0,         8'hB0, 4'd15, 0, 0, 8'd0,   0);
    // leftover partial codeword is dropped
    add_row(pcbd_pkg::OP_FINAL, 8'h00,  6'd0,  32'h0,         8'h80, 4'd1,  1, 0, 8'd0,   0);
    add_row(pcbd_pkg::OP_BYTE,  8'h00,  6'd0,  32'h0,         8'h6C, 4'd0,  0, 0, 8'd0,   0);
    add_row(pcbd_pkg::OP_FINAL, 8'h00,  6'd0,  32'h0,         8'hFF, 4'd0,  1, 0, 8'd0,   0);
    add_row(pcbd_pkg::OP_LOAD,  8'd9,   6'd0,  32'h0,         8'h00, 4'd0,  1, 0, 8'd0,   0);
    add_row(pcbd_pkg::OP_LOAD,  8'd3,   6'd63, 32'h0,         8'h00, 4'd0,  1, 0, 8'd0,   0);
    add_row(pcbd_pkg::OP_LOAD,  8'd4,   6'd40, 32'h0,         8'h00, 4'd0,  1, 0, 8'd0,   0);
    add_row(pcbd_pkg::OP_BYTE,  8'h00,  6'd0,  32'h0,         8'h7F, 4'd0,  0, 0, 8'd0,   0);
    add_row(pcbd_pkg::OP_FINAL, 8'h00,  6'd0,  32'h0,         8'h00, 4'd8,  0, 0, 8'd0,   0);
    add_row(pcbd_pkg::OP_LOAD,  8'd0,   6'd1,  32'h0,         8'h00, 4'd0,  1, 0, 8'd0,   0);
    add_row(pcbd_pkg::OP_FINAL, 8'h00,  6'd0,  32'h0,         8'h00, 4'd9,  0, 0, 8'd0,   0);

    foreach (script[i])
      push_request(script[i].req, script[i].typed, script[i].hit, script[i].sym, script[i].err);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_gap_pct   = gap_mix[ph];
      recv_stall_pct = stall_mix[ph];
      build_code_table();
      n = 0;
      while (n < STREAM_ITEMS) begin
        r = scrambled_request();
        skip = 1'b0;
        pick = $urandom_range(99);
        if (pick < 68) begin
          r.op = pcbd_pkg::OP_BYTE;
          while (coded_bits.size() < 8) spell_symbol();
          for (int i = 0; i < 8; i++) r.data[7-i] = coded_bits.pop_front();
        end else if (pick < 78) begin
          r.op = pcbd_pkg::OP_FINAL;
          if (coded_bits.size() == 0) spell_symbol();
          nb = (coded_bits.size() > 8) ? 8 : coded_bits.size();
          r.cnt = 4'(nb);
          for (int i = 0; i < nb; i++) r.data[7-i] = coded_bits.pop_front();
          coded_bits.delete();
        end else if (pick < 86) begin
          r.op = pcbd_pkg::OP_BYTE;
        end else if (pick < 91) begin
          r.op = pcbd_pkg::OP_FINAL;
          coded_bits.delete();
        end else if (pick < 96) begin
          r.op = pcbd_pkg::OP_LOAD;
        end else if (pick < 98) begin
          r.op = OP_NONE;
        end else begin
          wait_drained();
          skip = 1'b1;
        end
        if (!skip) begin
          push_request(r, 1'b0, 1'b0, '0, 1'b0);
          if (r.op != OP_NONE) n++;
        end
      end
      wait_drained();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (symbols_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && symbols_due.size() == 0) begin
      $display("tb_prefix_code_bit_decoder OK");
    end else begin
      $display("tb_prefix_code_bit_decoder NOT OK");
    end
    $finish;
  end

endmodule
